/* sv/sfr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants, types and the CRC-8 step for the stuffed frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int MAX_PACKET  = 64;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(MAX_PACKET + 1);

    localparam logic [7:0] SYM_START  = 8'h24;
    localparam logic [7:0] SYM_STOP   = 8'h3B;
    localparam logic [7:0] SYM_ESCAPE = 8'h2F;
    localparam logic [7:0] ESC_XOR    = 8'hFF;
    localparam logic [7:0] CRC_POLY   = 8'h8C;

    // Register byte address bit that selects the register word
    localparam int REG_SEL_BIT = 2;
    localparam logic REG_OWN_ADDRESS = 1'b0;

    typedef struct packed {
        logic             start;
        logic             empty;
        logic [CNT_W-1:0] count;
        logic [7:0]       opcode;
    } t_emit_req;

    // Reflected CRC-8 over one byte
    function automatic logic [7:0] crc8_push(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

/* sv/sfr_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

/* sv/sfr_rx.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_rx
// Destuffs received bytes, tracks the frame phase and CRC, writes payload
// bytes to the store and requests readout on a good stop.
// ----------------------------------------------------------------------------
module sfr_rx (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic [7:0]                i_byte,
    input  wire logic [7:0]                i_own_address,
    input  wire logic                      i_busy,
    output logic                           o_stall,
    output logic                           o_we,
    output logic [sfr_pkg::ADDR_W-1:0]     o_waddr,
    output logic [7:0]                     o_wdata,
    output sfr_pkg::t_emit_req             o_req
);
    import sfr_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ADDRESS,
        PH_OPCODE,
        PH_DATA
    } t_phase;

    t_phase           r_phase;
    logic             r_esc;
    logic [7:0]       r_crc;
    logic [CNT_W-1:0] r_count;
    logic [7:0]       r_opcode;

    logic       accept;
    logic [7:0] dec;
    logic       is_esc;
    logic       is_stop;
    logic       room;
    logic [7:0] crc_next;

    assign o_stall  = i_busy;
    assign accept   = i_valid && !i_busy;
    assign dec      = r_esc ? (i_byte ^ ESC_XOR) : i_byte;
    assign is_esc   = !r_esc && (i_byte == SYM_ESCAPE);
    assign is_stop  = !r_esc && (i_byte == SYM_STOP);
    assign room     = r_count < CNT_W'(MAX_PACKET);
    assign crc_next = crc8_push(r_crc, dec);

    assign o_we    = accept && !is_esc && !is_stop && (r_phase == PH_DATA) && room;
    assign o_waddr = r_count[ADDR_W-1:0];
    assign o_wdata = dec;

    always_comb begin
        o_req.start  = accept && is_stop && (r_phase != PH_IDLE)
                       && (r_crc == 8'h00) && (r_count != '0);
        o_req.empty  = (r_count == CNT_W'(1));
        o_req.count  = r_count;
        o_req.opcode = r_opcode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_esc    <= 1'b0;
            r_crc    <= 8'h00;
            r_count  <= '0;
            r_opcode <= 8'h00;
        end else if (accept) begin
            if (is_esc) begin
                r_esc <= 1'b1;
            end else begin
                r_esc <= 1'b0;
                if (is_stop) begin
                    r_phase <= PH_IDLE;
                end else begin
                    case (r_phase)
                        PH_IDLE: begin
                            if (dec == SYM_START) begin
                                r_crc   <= 8'h00;
                                r_count <= '0;
                                r_phase <= PH_ADDRESS;
                            end
                        end
                        PH_ADDRESS: begin
                            r_phase <= (dec == i_own_address) ? PH_OPCODE : PH_IDLE;
                            r_crc   <= crc_next;
                        end
                        PH_OPCODE: begin
                            r_opcode <= dec;
                            r_phase  <= PH_DATA;
                            r_crc    <= crc_next;
                        end
                        PH_DATA: begin
                            if (room) begin
                                r_crc   <= crc_next;
                                r_count <= r_count + CNT_W'(1);
                            end else begin
                                // overflow: drop the frame
                                r_phase <= PH_IDLE;
                            end
                        end
                        default: r_phase <= PH_IDLE;
                    endcase
                end
            end
        end
    end

    a_req_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req.start |-> !i_busy)
        else $error("readout requested while busy");
    a_stop_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && is_stop |=> r_phase == PH_IDLE)
        else $error("stop did not return to idle");
    a_write_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> r_count < CNT_W'(MAX_PACKET) && r_phase == PH_DATA)
        else $error("store write out of frame or bound");

endmodule
`default_nettype wire

/* sv/sfr_emit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_emit
// Reads the stored payload back after a good frame and drives the result
// output register.
// ----------------------------------------------------------------------------
module sfr_emit (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire sfr_pkg::t_emit_req    i_req,
    output logic                       o_busy,
    output logic                       o_re,
    output logic [sfr_pkg::ADDR_W-1:0] o_raddr,
    input  wire logic [7:0]            i_rdata,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [7:0]                 o_frame_opcode,
    output logic [7:0]                 o_payload_byte,
    output logic                       o_has_payload,
    output logic                       o_last
);
    import sfr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_EMPTY
    } t_state;

    t_state            r_state;
    logic [ADDR_W-1:0] r_idx;
    logic [ADDR_W-1:0] r_last_idx;
    logic [7:0]        r_opcode;
    logic              can_load;
    logic              at_last;
    logic              load;

    assign o_busy   = (r_state != S_IDLE);
    assign o_re     = (r_state == S_READ);
    assign o_raddr  = r_idx;
    assign can_load = !o_valid || !i_stall;
    assign at_last  = (r_idx == r_last_idx);
    assign load     = (r_state inside {S_WAIT, S_EMPTY}) && can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (load) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        // hold the opcode aside, the output may still be stalled
                        r_opcode   <= i_req.opcode;
                        r_idx      <= '0;
                        // the final stored byte is the CRC, leave it out
                        r_last_idx <= ADDR_W'(i_req.count - CNT_W'(2));
                        r_state    <= i_req.empty ? S_EMPTY : S_READ;
                    end
                end
                S_READ: r_state <= S_WAIT;
                S_WAIT: begin
                    if (can_load) begin
                        o_frame_opcode <= r_opcode;
                        o_payload_byte <= i_rdata;
                        o_has_payload  <= 1'b1;
                        o_last         <= at_last;
                        r_idx          <= r_idx + ADDR_W'(1);
                        r_state        <= at_last ? S_IDLE : S_READ;
                    end
                end
                S_EMPTY: begin
                    if (can_load) begin
                        o_frame_opcode <= r_opcode;
                        o_payload_byte <= 8'h00;
                        o_has_payload  <= 1'b0;
                        o_last         <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_payload |-> o_last)
        else $error("empty-payload result not marked last");
    a_read_then_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |=> r_state == S_WAIT)
        else $error("read not followed by wait");
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WAIT && can_load && at_last |=> r_state == S_IDLE && o_valid && o_last)
        else $error("final result did not end readout");
    a_req_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> r_state == S_IDLE)
        else $error("readout request while not idle");

endmodule
`default_nettype wire

/* sv/stuffed_frame_receiver_crc8.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_crc8
// Byte-stuffed frame receiver with CRC-8 check and payload readout.
// ----------------------------------------------------------------------------
// Input: one received byte per cycle while no readout runs.
// Readout: after a good stop, each result takes a RAM read, then an
//   output register load, through the single read port of the payload RAM;
//   an empty payload needs no RAM read and loads its result directly;
//   input stalls until the last result is loaded.
// Reset: synchronous, active low; clears control state and own_address.
//   The payload RAM is not cleared.
module stuffed_frame_receiver_crc8 (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_frame_opcode,
    output logic [7:0]       o_payload_byte,
    output logic             o_has_payload,
    output logic             o_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import sfr_pkg::*;

    logic [7:0]        r_own_address;
    logic              reg_sel;
    logic              busy;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic [7:0]        rdata;
    t_emit_req         req;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[REG_SEL_BIT] == REG_OWN_ADDRESS);
    assign prdata  = reg_sel ? {24'h0, r_own_address} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= 8'h00;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_own_address <= pwdata[7:0];
        end
    end

    sfr_rx u_rx (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .i_byte        (i_rx_byte),
        .i_own_address (r_own_address),
        .i_busy        (busy),
        .o_stall       (o_in_stall),
        .o_we          (we),
        .o_waddr       (waddr),
        .o_wdata       (wdata),
        .o_req         (req)
    );

    sfr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    sfr_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (req),
        .o_busy         (busy),
        .o_re           (re),
        .o_raddr        (raddr),
        .i_rdata        (rdata),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_frame_opcode (o_frame_opcode),
        .o_payload_byte (o_payload_byte),
        .o_has_payload  (o_has_payload),
        .o_last         (o_last)
    );

endmodule
`default_nettype wire
